// File: hw/rtl/render_pixel_to_rgba8_core_macros.svh
// Assertion macros for the render_pixel_to_rgba8_core RTL.
// Needs a clk and an active-high rst in the scope of each use.
`ifndef RENDER_PIXEL_TO_RGBA8_CORE_MACROS_SVH
`define RENDER_PIXEL_TO_RGBA8_CORE_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset
`define RPR8_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rpr8: assertion failed");

// Antecedent in one cycle implies consequent in the next
`define RPR8_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpr8: next-cycle assertion failed");

`else

`define RPR8_ASSERT(lbl, prop)
`define RPR8_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/rpr8_pkg.sv
// Shared types and constants for the RGBA8 pixel converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rpr8_pkg;

  // Configuration register layout
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int FMT_W       = 4;
  localparam int DIM_REG_W   = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam int DEFAULT_MAX_DIM = 4096;

  // Output coordinate width
  localparam int POS_W = 12;

  // Source pixel formats
  typedef enum logic [FMT_W-1:0] {
    FMT_U8_GRAY  = 4'd0,
    FMT_U8_RGBA  = 4'd1,
    FMT_U8_RGB   = 4'd2,
    FMT_F32_RGBA = 4'd3,
    FMT_F32_GRAY = 4'd4,
    FMT_F32_RGB  = 4'd5,
    FMT_F16_GRAY = 4'd6,
    FMT_F16_RGBA = 4'd7,
    FMT_F16_RGB  = 4'd8,
    FMT_ID       = 4'd9,
    FMT_DEPTH    = 4'd10
  } pixel_format_t;

  // ID colouring hash multipliers (only the low byte matters for the result)
  localparam logic [31:0] HASH_RED   = 32'd1315423911;
  localparam logic [31:0] HASH_GREEN = 32'd2654435761;
  localparam logic [31:0] HASH_BLUE  = 32'd374761393;

  localparam logic [7:0] BYTE_MAX = 8'hFF;

  typedef struct packed {
    logic [31:0] chan0;
    logic [31:0] chan1;
    logic [31:0] chan2;
    logic [31:0] chan3;
  } pixel_in_t;

  typedef struct packed {
    logic [POS_W-1:0] dest_x;
    logic [POS_W-1:0] dest_y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [POS_W-1:0] dest_x;
    logic [POS_W-1:0] dest_y;
    logic             frame_end;
  } raster_pos_t;

endpackage

// File: hw/rtl/render_pixel_to_rgba8_core.sv
// Converts a stream of source pixels (8-bit, float32, half, ID or depth) to
// RGBA8 with a destination column and a vertically flipped row. A new pixel
// is accepted every clock while the output is not stalled: each pixel passes
// an input register, one pass of conversion logic (float rounding shifter,
// ID hash, format mux, raster counters) and a result register that drives
// dst_pixel; the sustained rate is one pixel per cycle while the output
// accepts, set by that single conversion pass. A stalled output holds both
// registers and drops src_ready. Configuration writes are taken in any cycle
// (cfg_ready is tied high) and must only be issued while no pixel is in
// flight. There is no start-up clearing pass.
// Depends on rpr8_pkg, rpr8_pixel_conv, rpr8_raster_cnt and the macro header.
`timescale 1ns / 1ps
`include "render_pixel_to_rgba8_core_macros.svh"

module render_pixel_to_rgba8_core #(
  parameter int MAX_DIM = rpr8_pkg::DEFAULT_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst,
  // Source pixels
  input  logic                             src_valid,
  output logic                             src_ready,
  input  rpr8_pkg::pixel_in_t              src_pixel,
  // Converted pixels
  output logic                             dst_valid,
  input  logic                             dst_ready,
  output rpr8_pkg::pixel_out_t             dst_pixel,
  // Register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rpr8_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rpr8_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [rpr8_pkg::FMT_W-1:0]     pixel_format;
  logic [rpr8_pkg::DIM_REG_W-1:0] frame_width;
  logic [rpr8_pkg::DIM_REG_W-1:0] frame_height;

  logic                  s1_valid;
  rpr8_pkg::pixel_in_t   s1_pixel;
  logic                  out_en;
  logic                  s1_adv;
  rpr8_pkg::rgba_t       colour;
  rpr8_pkg::raster_pos_t pos;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= rpr8_pkg::FMT_U8_GRAY;
      frame_width  <= rpr8_pkg::DIM_REG_W'(1);
      frame_height <= rpr8_pkg::DIM_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpr8_pkg::REG_PIXEL_FORMAT: pixel_format <= cfg_data[rpr8_pkg::FMT_W-1:0];
        rpr8_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[rpr8_pkg::DIM_REG_W-1:0];
        rpr8_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[rpr8_pkg::DIM_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control
  assign out_en    = !dst_valid || dst_ready;
  assign s1_adv    = s1_valid && out_en;
  assign src_ready = !s1_valid || out_en;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_ready) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      s1_pixel <= src_pixel;
    end
  end

  rpr8_pixel_conv u_pixel_conv (
    .pixel_format(pixel_format),
    .pixel       (s1_pixel),
    .colour      (colour)
  );

  rpr8_raster_cnt #(
    .MAX_DIM(MAX_DIM)
  ) u_raster_cnt (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .advance     (s1_adv),
    .pos         (pos)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_en) begin
      dst_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      dst_pixel.dest_x    <= pos.dest_x;
      dst_pixel.dest_y    <= pos.dest_y;
      dst_pixel.red       <= colour.red;
      dst_pixel.green     <= colour.green;
      dst_pixel.blue      <= colour.blue;
      dst_pixel.alpha     <= colour.alpha;
      dst_pixel.frame_end <= pos.frame_end;
    end
  end

  // Checks
  `RPR8_ASSERT(a_full_blocks_src, (s1_valid && dst_valid && !dst_ready) |-> !src_ready)
  `RPR8_ASSERT_NEXT(a_stage_moves_to_dst, s1_adv, dst_valid)
  `RPR8_ASSERT(a_frame_end_bottom_row, (dst_valid && dst_pixel.frame_end) |-> (dst_pixel.dest_y == '0))

endmodule

// File: hw/rtl/rpr8_chan_conv.sv
// One channel converter: float32 or half raw bits to an 8-bit value.
// Uses rpr8_pkg for BYTE_MAX; instantiated by rpr8_pixel_conv.
`timescale 1ns / 1ps

module rpr8_chan_conv (
  input  logic [31:0] raw,
  input  logic        half,
  input  logic        vec,
  output logic [7:0]  value
);

  // Above this shift the rounded result is always zero
  localparam logic [7:0] SHIFT_LIMIT = 8'd32;

  logic        neg;
  logic        exp_max;
  logic        is_zero;
  logic        frac_nz;
  logic        ge_one;
  logic [23:0] mant;
  logic [7:0]  shift;
  logic [31:0] scaled;
  logic [32:0] rounded;
  logic [32:0] quot;

  // Unpack to a common mantissa and right-shift amount
  always_comb begin
    if (half) begin
      neg     = raw[15];
      exp_max = (raw[14:10] == 5'h1F);
      is_zero = (raw[14:0] == 15'd0);
      frac_nz = (raw[9:0] != 10'd0);
      ge_one  = (raw[14:10] >= 5'd15);
      if (raw[14:10] == 5'd0) begin
        mant  = {14'd0, raw[9:0]};
        shift = 8'd24;
      end else begin
        mant  = {13'd0, 1'b1, raw[9:0]};
        shift = 8'd25 - {3'd0, raw[14:10]};
      end
    end else begin
      neg     = raw[31];
      exp_max = (raw[30:23] == 8'hFF);
      is_zero = (raw[30:0] == 31'd0);
      frac_nz = (raw[22:0] != 23'd0);
      ge_one  = (raw[30:23] >= 8'd127);
      if (raw[30:23] == 8'd0) begin
        mant  = {1'b0, raw[22:0]};
        shift = 8'd149;
      end else begin
        mant  = {1'b1, raw[22:0]};
        shift = 8'd150 - raw[30:23];
      end
    end
  end

  // floor(mant * 255 / 2^shift + 0.5)
  assign scaled  = {mant, 8'h00} - {8'h00, mant};
  assign rounded = {1'b0, scaled} + (33'd1 << (shift - 8'd1));
  assign quot    = rounded >> shift;

  // Special values first, then the fraction path
  always_comb begin
    if (exp_max) begin
      // NaN and +inf saturate in vector formats; -inf and scalar give zero
      value = (vec && (frac_nz || !neg)) ? rpr8_pkg::BYTE_MAX : 8'd0;
    end else if (is_zero || neg) begin
      value = 8'd0;
    end else if (ge_one) begin
      value = rpr8_pkg::BYTE_MAX;
    end else if (shift > SHIFT_LIMIT) begin
      value = 8'd0;
    end else begin
      value = quot[7:0];
    end
  end

endmodule

// File: hw/rtl/rpr8_pixel_conv.sv
// Format decode and colour selection for one source pixel.
// Uses rpr8_pkg types and four rpr8_chan_conv instances.
`timescale 1ns / 1ps

module rpr8_pixel_conv (
  input  logic [rpr8_pkg::FMT_W-1:0] pixel_format,
  input  rpr8_pkg::pixel_in_t        pixel,
  output rpr8_pkg::rgba_t            colour
);

  logic       vec;
  logic       half;
  logic [7:0] cv0;
  logic [7:0] cv1;
  logic [7:0] cv2;
  logic [7:0] cv3;

  // Float unpacking mode
  always_comb begin
    vec  = 1'b0;
    half = 1'b0;
    case (pixel_format)
      rpr8_pkg::FMT_F32_RGBA, rpr8_pkg::FMT_F32_RGB: begin
        vec = 1'b1;
      end
      rpr8_pkg::FMT_F16_RGBA, rpr8_pkg::FMT_F16_RGB: begin
        vec  = 1'b1;
        half = 1'b1;
      end
      rpr8_pkg::FMT_F16_GRAY: begin
        half = 1'b1;
      end
      default: begin
        vec  = 1'b0;
        half = 1'b0;
      end
    endcase
  end

  rpr8_chan_conv u_conv0 (.raw(pixel.chan0), .half(half), .vec(vec), .value(cv0));
  rpr8_chan_conv u_conv1 (.raw(pixel.chan1), .half(half), .vec(vec), .value(cv1));
  rpr8_chan_conv u_conv2 (.raw(pixel.chan2), .half(half), .vec(vec), .value(cv2));
  rpr8_chan_conv u_conv3 (.raw(pixel.chan3), .half(half), .vec(vec), .value(cv3));

  // Channel selection per format; unknown codes leave the buffer white
  always_comb begin
    logic [15:0] hash_r;
    logic [15:0] hash_g;
    logic [15:0] hash_b;
    // low byte of id * K depends only on the low bytes of both
    hash_r = pixel.chan0[7:0] * rpr8_pkg::HASH_RED[7:0];
    hash_g = pixel.chan0[7:0] * rpr8_pkg::HASH_GREEN[7:0];
    hash_b = pixel.chan0[7:0] * rpr8_pkg::HASH_BLUE[7:0];
    colour.red   = rpr8_pkg::BYTE_MAX;
    colour.green = rpr8_pkg::BYTE_MAX;
    colour.blue  = rpr8_pkg::BYTE_MAX;
    colour.alpha = rpr8_pkg::BYTE_MAX;
    case (pixel_format)
      rpr8_pkg::FMT_U8_GRAY: begin
        colour.red   = pixel.chan0[7:0];
        colour.green = pixel.chan0[7:0];
        colour.blue  = pixel.chan0[7:0];
      end
      rpr8_pkg::FMT_U8_RGBA: begin
        colour.red   = pixel.chan0[7:0];
        colour.green = pixel.chan1[7:0];
        colour.blue  = pixel.chan2[7:0];
        colour.alpha = pixel.chan3[7:0];
      end
      rpr8_pkg::FMT_U8_RGB: begin
        colour.red   = pixel.chan0[7:0];
        colour.green = pixel.chan1[7:0];
        colour.blue  = pixel.chan2[7:0];
      end
      rpr8_pkg::FMT_F32_RGBA, rpr8_pkg::FMT_F16_RGBA: begin
        colour.red   = cv0;
        colour.green = cv1;
        colour.blue  = cv2;
        colour.alpha = cv3;
      end
      rpr8_pkg::FMT_F32_RGB, rpr8_pkg::FMT_F16_RGB: begin
        colour.red   = cv0;
        colour.green = cv1;
        colour.blue  = cv2;
      end
      rpr8_pkg::FMT_F32_GRAY, rpr8_pkg::FMT_F16_GRAY, rpr8_pkg::FMT_DEPTH: begin
        colour.red   = cv0;
        colour.green = cv0;
        colour.blue  = cv0;
      end
      rpr8_pkg::FMT_ID: begin
        if (pixel.chan0 == 32'd0) begin
          colour.red   = 8'd0;
          colour.green = 8'd0;
          colour.blue  = 8'd0;
        end else begin
          colour.red   = hash_r[7:0];
          colour.green = hash_g[7:0];
          colour.blue  = hash_b[7:0];
        end
      end
      default: begin
        colour.alpha = rpr8_pkg::BYTE_MAX;
      end
    endcase
  end

endmodule

// File: hw/rtl/rpr8_raster_cnt.sv
// Column and row counters that walk the frame and give the column and a flipped row.
// Uses rpr8_pkg for widths and the position struct.
`timescale 1ns / 1ps

module rpr8_raster_cnt #(
  parameter int MAX_DIM = rpr8_pkg::DEFAULT_MAX_DIM
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rpr8_pkg::DIM_REG_W-1:0] frame_width,
  input  logic [rpr8_pkg::DIM_REG_W-1:0] frame_height,
  input  logic                           advance,
  output rpr8_pkg::raster_pos_t          pos
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int EW = (DW > rpr8_pkg::DIM_REG_W) ? DW : rpr8_pkg::DIM_REG_W;
  localparam int XW = (DW > rpr8_pkg::POS_W) ? DW : rpr8_pkg::POS_W;

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] column_count_next;
  logic [CW-1:0] row_count_next;
  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;
  logic [DW-1:0] col_eff;
  logic [DW-1:0] row_eff;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] row_inc;
  logic [DW-1:0] y_val;
  logic [XW-1:0] x_ext;
  logic [XW-1:0] y_ext;

  // Zero counts as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [DW-1:0] eff_dim(input logic [rpr8_pkg::DIM_REG_W-1:0] dim);
    logic [EW-1:0] dim_ext;
    dim_ext = EW'(dim);
    if (dim_ext == EW'(0)) begin
      eff_dim = DW'(1);
    end else if (dim_ext > EW'(MAX_DIM)) begin
      eff_dim = DW'(MAX_DIM);
    end else begin
      eff_dim = DW'(dim_ext);
    end
  endfunction

  assign w_eff = eff_dim(frame_width);
  assign h_eff = eff_dim(frame_height);

  // A counter left beyond a shrunk bound restarts at zero
  assign col_eff = (DW'(column_count) >= w_eff) ? DW'(0) : DW'(column_count);
  assign row_eff = (DW'(row_count) >= h_eff) ? DW'(0) : DW'(row_count);
  assign col_inc = col_eff + DW'(1);
  assign row_inc = row_eff + DW'(1);

  // Output coordinates
  assign y_val         = h_eff - DW'(1) - row_eff;
  assign x_ext         = XW'(col_eff);
  assign y_ext         = XW'(y_val);
  assign pos.dest_x    = x_ext[rpr8_pkg::POS_W-1:0];
  assign pos.dest_y    = y_ext[rpr8_pkg::POS_W-1:0];
  assign pos.frame_end = (col_eff == w_eff - DW'(1)) && (row_eff == h_eff - DW'(1));

  // Raster step
  always_comb begin
    if (col_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= h_eff) ? '0 : CW'(row_inc);
    end else begin
      column_count_next = CW'(col_inc);
      row_count_next    = CW'(row_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// File: tb/sv/render_pixel_to_rgba8_core_tb.sv
// Self-checking testbench for render_pixel_to_rgba8_core: source pixels and register
// writes with random idling on both sides; every RGBA8 result is predicted and compared.
// Depends on rpr8_pkg and the core RTL only.
`timescale 1ns / 1ps

module render_pixel_to_rgba8_core_tb;

  localparam logic [rpr8_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [rpr8_pkg::FMT_W-1:0] FMT_RESERVED_LO = 4'd11;
  localparam logic [rpr8_pkg::FMT_W-1:0] FMT_RESERVED_HI = 4'd15;
  localparam int STALL_MAX = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1350;

  logic clk;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_ready;
  rpr8_pkg::pixel_in_t src_pixel = '0;
  logic dst_valid;
  logic dst_ready = 1'b0;
  rpr8_pkg::pixel_out_t dst_pixel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rpr8_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rpr8_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block's registers and raster counters
  logic [rpr8_pkg::FMT_W-1:0] fmt_reg = rpr8_pkg::FMT_U8_GRAY;
  logic [rpr8_pkg::DIM_REG_W-1:0] width_reg = 13'd1;
  logic [rpr8_pkg::DIM_REG_W-1:0] height_reg = 13'd1;
  int col_pos = 0;
  int row_pos = 0;

  rpr8_pkg::pixel_out_t pending_pixels[$];
  rpr8_pkg::pixel_out_t head_pixel;
  int errors = 0;
  int quiet_cycles = 0;
  bit src_no_idle = 1'b0;
  bit dst_no_idle = 1'b0;

  render_pixel_to_rgba8_core dut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_pixel(src_pixel),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_pixel(dst_pixel),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor(mant * 2^-sh * 255 + 0.5) in integers
  function automatic logic [7:0] round_unit(logic [63:0] mant, int unsigned sh);
    logic [63:0] scaled;
    if (sh > 40) return 8'd0;
    scaled = (mant * 64'd255 + (64'd1 << (sh - 1))) >> sh;
    return scaled[7:0];
  endfunction

  function automatic logic [7:0] f32_to_byte(logic [31:0] bits, bit vec);
    logic [7:0] ef;
    logic [22:0] fr;
    ef = bits[30:23];
    fr = bits[22:0];
    if (ef == 8'hFF) begin
      // -inf is black everywhere; NaN and +inf saturate only in colour formats
      if (fr == 0 && bits[31]) return 8'd0;
      return vec ? rpr8_pkg::BYTE_MAX : 8'd0;
    end
    if (bits[31] || (ef == 0 && fr == 0)) return 8'd0;
    if (ef >= 8'd127) return rpr8_pkg::BYTE_MAX;
    if (ef == 0) return round_unit({41'd0, fr}, 149);
    return round_unit({40'd0, 1'b1, fr}, 150 - ef);
  endfunction

  function automatic logic [7:0] f16_to_byte(logic [31:0] bits, bit vec);
    logic [4:0] ef;
    logic [9:0] fr;
    ef = bits[14:10];
    fr = bits[9:0];
    if (ef == 5'h1F) begin
      if (fr == 0 && bits[15]) return 8'd0;
      return vec ? rpr8_pkg::BYTE_MAX : 8'd0;
    end
    if (bits[15] || (ef == 0 && fr == 0)) return 8'd0;
    if (ef >= 5'd15) return rpr8_pkg::BYTE_MAX;
    if (ef == 0) return round_unit({54'd0, fr}, 24);
    return round_unit({53'd0, 1'b1, fr}, 25 - ef);
  endfunction

  // Zero counts as one, anything past the maximum as the maximum
  function automatic int eff_dim(logic [rpr8_pkg::DIM_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > rpr8_pkg::DEFAULT_MAX_DIM) return rpr8_pkg::DEFAULT_MAX_DIM;
    return int'(r);
  endfunction

  // Work out the converted pixel for one accepted source pixel and step the raster
  function automatic void convert_pixel(rpr8_pkg::pixel_in_t p);
    int w;
    int h;
    logic [31:0] prod;
    rpr8_pkg::pixel_out_t o;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    o.red = rpr8_pkg::BYTE_MAX;
    o.green = rpr8_pkg::BYTE_MAX;
    o.blue = rpr8_pkg::BYTE_MAX;
    o.alpha = rpr8_pkg::BYTE_MAX;
    case (fmt_reg)
      rpr8_pkg::FMT_U8_GRAY: begin
        o.red = p.chan0[7:0];
        o.green = o.red;
        o.blue = o.red;
      end
      rpr8_pkg::FMT_U8_RGBA: begin
        o.red = p.chan0[7:0];
        o.green = p.chan1[7:0];
        o.blue = p.chan2[7:0];
        o.alpha = p.chan3[7:0];
      end
      rpr8_pkg::FMT_U8_RGB: begin
        o.red = p.chan0[7:0];
        o.green = p.chan1[7:0];
        o.blue = p.chan2[7:0];
      end
      rpr8_pkg::FMT_F32_RGBA: begin
        o.red = f32_to_byte(p.chan0, 1'b1);
        o.green = f32_to_byte(p.chan1, 1'b1);
        o.blue = f32_to_byte(p.chan2, 1'b1);
        o.alpha = f32_to_byte(p.chan3, 1'b1);
      end
      rpr8_pkg::FMT_F32_GRAY, rpr8_pkg::FMT_DEPTH: begin
        o.red = f32_to_byte(p.chan0, 1'b0);
        o.green = o.red;
        o.blue = o.red;
      end
      rpr8_pkg::FMT_F32_RGB: begin
        o.red = f32_to_byte(p.chan0, 1'b1);
        o.green = f32_to_byte(p.chan1, 1'b1);
        o.blue = f32_to_byte(p.chan2, 1'b1);
      end
      rpr8_pkg::FMT_F16_GRAY: begin
        o.red = f16_to_byte(p.chan0, 1'b0);
        o.green = o.red;
        o.blue = o.red;
      end
      rpr8_pkg::FMT_F16_RGBA: begin
        o.red = f16_to_byte(p.chan0, 1'b1);
        o.green = f16_to_byte(p.chan1, 1'b1);
        o.blue = f16_to_byte(p.chan2, 1'b1);
        o.alpha = f16_to_byte(p.chan3, 1'b1);
      end
      rpr8_pkg::FMT_F16_RGB: begin
        o.red = f16_to_byte(p.chan0, 1'b1);
        o.green = f16_to_byte(p.chan1, 1'b1);
        o.blue = f16_to_byte(p.chan2, 1'b1);
      end
      rpr8_pkg::FMT_ID: begin
        if (p.chan0 == 0) begin
          o.red = 8'd0;
          o.green = 8'd0;
          o.blue = 8'd0;
        end else begin
          prod = p.chan0 * rpr8_pkg::HASH_RED;
          o.red = prod[7:0];
          prod = p.chan0 * rpr8_pkg::HASH_GREEN;
          o.green = prod[7:0];
          prod = p.chan0 * rpr8_pkg::HASH_BLUE;
          o.blue = prod[7:0];
        end
      end
      default: ;  // reserved codes leave the buffer white
    endcase
    o.dest_x = 12'(col_pos);
    o.dest_y = 12'(h - 1 - row_pos);
    o.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
    pending_pixels.push_back(o);
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  // Random channel word, biased towards the interesting float and half ranges
  function automatic logic [31:0] rand_chan();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      3, 4: v[30:23] = 8'($urandom_range(100, 127));
      5: begin
        v[30:23] = 8'hFF;
        if ($urandom_range(0, 1) == 0) v[22:0] = '0;
      end
      6, 7: v[14:10] = 5'($urandom_range(0, 15));
      8: begin
        v[14:10] = 5'h1F;
        if ($urandom_range(0, 1) == 0) v[9:0] = '0;
      end
      9: v[30:23] = 8'h00;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) v[31] = 1'b0;
    return v;
  endfunction

  function automatic logic [rpr8_pkg::DIM_REG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 13'($urandom_range(rpr8_pkg::DEFAULT_MAX_DIM + 1, 8191));
      2: return 13'(rpr8_pkg::DEFAULT_MAX_DIM);
      3: return 13'($urandom_range(100, 400));
      default: return 13'($urandom_range(1, 16));
    endcase
  endfunction

  // Send one source pixel, after a random gap unless src_no_idle is set, and predict its result
  task automatic push_pixel(input logic [31:0] c0, c1, c2, c3);
    int gap;
    rpr8_pkg::pixel_in_t px;
    gap = src_no_idle ? 0 : $urandom_range(0, STALL_MAX);
    px.chan0 = c0;
    px.chan1 = c1;
    px.chan2 = c2;
    px.chan3 = c3;
    @(negedge clk);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_pixel <= px;
    src_valid <= 1'b1;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    convert_pixel(px);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    src_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rpr8_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rpr8_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rpr8_pkg::REG_PIXEL_FORMAT: fmt_reg = val[rpr8_pkg::FMT_W-1:0];
      rpr8_pkg::REG_FRAME_WIDTH: width_reg = val;
      rpr8_pkg::REG_FRAME_HEIGHT: height_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain, then program format (junk in the upper bits) and both dimensions
  task automatic set_frame(input logic [rpr8_pkg::FMT_W-1:0] fmt,
                           input logic [rpr8_pkg::DIM_REG_W-1:0] w, h);
    wait_idle();
    write_reg(rpr8_pkg::REG_PIXEL_FORMAT, {9'($urandom), fmt});
    write_reg(rpr8_pkg::REG_FRAME_WIDTH, w);
    write_reg(rpr8_pkg::REG_FRAME_HEIGHT, h);
  endtask

  task automatic test_byte_formats();
    set_frame(rpr8_pkg::FMT_U8_GRAY, 13'd1, 13'd1);
    push_pixel(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pixel(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    set_frame(rpr8_pkg::FMT_U8_RGBA, 13'd1, 13'd1);
    push_pixel(32'hABCD_EF12, 32'h0000_00FF, 32'h1234_5600, 32'hFFFF_FF80);
    set_frame(rpr8_pkg::FMT_U8_RGB, 13'd1, 13'd1);
    push_pixel(32'h0000_0001, 32'hFFFF_FF7F, 32'h8000_00FE, 32'h0000_0000);
  endtask

  task automatic test_float_specials();
    // NaN, +inf, -inf, -0 then one, half, smallest subnormal, just below one
    set_frame(rpr8_pkg::FMT_F32_RGBA, 13'd1, 13'd1);
    push_pixel(32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h8000_0000);
    push_pixel(32'h3F80_0000, 32'h3F00_0000, 32'h0000_0001, 32'h3F7F_FFFF);
    set_frame(rpr8_pkg::FMT_F32_RGB, 13'd1, 13'd1);
    push_pixel(32'h4000_0000, 32'h3B80_0000, 32'hBF00_0000, 32'h7FFF_FFFF);
    // scalar formats blank every non-finite value
    set_frame(rpr8_pkg::FMT_F32_GRAY, 13'd1, 13'd1);
    push_pixel(32'h7F80_0001, 32'h0, 32'h0, 32'h0);
    push_pixel(32'h7F80_0000, 32'h0, 32'h0, 32'h0);
    push_pixel(32'h3E80_0000, 32'h0, 32'h0, 32'h0);
    set_frame(rpr8_pkg::FMT_DEPTH, 13'd1, 13'd1);
    push_pixel(32'hFF80_0000, 32'h0, 32'h0, 32'h0);
    push_pixel(32'h3F40_0000, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_half_specials();
    // halves sit in the low 16 bits; the upper half is junk
    set_frame(rpr8_pkg::FMT_F16_RGBA, 13'd1, 13'd1);
    push_pixel(32'hFFFF_7C00, 32'h0000_FC00, 32'h1234_7E00, 32'hABCD_3C00);
    push_pixel(32'h0000_3800, 32'hFFFF_0001, 32'h0000_8000, 32'h0000_3BFF);
    set_frame(rpr8_pkg::FMT_F16_RGB, 13'd1, 13'd1);
    push_pixel(32'h0000_4000, 32'h0000_1C00, 32'h0000_B800, 32'h0000_7FFF);
    set_frame(rpr8_pkg::FMT_F16_GRAY, 13'd1, 13'd1);
    push_pixel(32'hFFFF_7C00, 32'h0, 32'h0, 32'h0);
    push_pixel(32'h0000_7E00, 32'h0, 32'h0, 32'h0);
    push_pixel(32'h0000_0400, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_id_colours();
    set_frame(rpr8_pkg::FMT_ID, 13'd1, 13'd1);
    push_pixel(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    push_pixel(32'h0000_0001, 32'h0, 32'h0, 32'h0);
    push_pixel(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_reserved_codes();
    set_frame(FMT_RESERVED_LO, 13'd1, 13'd1);
    push_pixel(32'h1234_5678, 32'h0, 32'h0, 32'h0);
    set_frame(FMT_RESERVED_HI, 13'd1, 13'd1);
    push_pixel(32'h0, 32'h0, 32'h0, 32'h0);
    // a write to the unused index must change nothing
    wait_idle();
    write_reg(REG_UNUSED, 13'($urandom));
    push_pixel(32'h0000_00FF, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_dimension_limits();
    set_frame(rpr8_pkg::FMT_U8_RGB, 13'd0, 13'd3);
    repeat (6) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    set_frame(rpr8_pkg::FMT_U8_GRAY, 13'h1FFF, 13'd0);
    repeat (5) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    set_frame(rpr8_pkg::FMT_F16_RGB, 13'd3, 13'h1FFF);
    repeat (7) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    set_frame(rpr8_pkg::FMT_ID, 13'(rpr8_pkg::DEFAULT_MAX_DIM),
              13'(rpr8_pkg::DEFAULT_MAX_DIM));
    repeat (3) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    // two full rows wide enough to carry the upper column bits
    src_no_idle = 1'b1;
    set_frame(rpr8_pkg::FMT_U8_RGBA, 13'd260, 13'd2);
    repeat (530) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    src_no_idle = 1'b0;
  endtask

  task automatic test_counter_shrink();
    set_frame(rpr8_pkg::FMT_U8_GRAY, 13'd7, 13'd5);
    repeat (17) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    // both counters now sit past the new bounds
    wait_idle();
    write_reg(rpr8_pkg::REG_FRAME_WIDTH, 13'd2);
    write_reg(rpr8_pkg::REG_FRAME_HEIGHT, 13'd2);
    repeat (5) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    set_frame(rpr8_pkg::FMT_U8_GRAY, 13'd9, 13'd4);
    repeat (7) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    wait_idle();
    write_reg(rpr8_pkg::REG_FRAME_WIDTH, 13'd3);
    repeat (4) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endtask

  task automatic test_random_frames();
    int sent;
    int n;
    logic [rpr8_pkg::FMT_W-1:0] fmt;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        fmt = 4'($urandom_range(FMT_RESERVED_LO, FMT_RESERVED_HI));
      else
        fmt = 4'($urandom_range(rpr8_pkg::FMT_U8_GRAY, rpr8_pkg::FMT_DEPTH));
      src_no_idle = ($urandom_range(0, 3) == 0);
      dst_no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        // keep the frame and its counters, touch only the format
        wait_idle();
        write_reg(rpr8_pkg::REG_PIXEL_FORMAT, {9'($urandom), fmt});
        if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, 13'($urandom));
      end else begin
        set_frame(fmt, pick_dim(), pick_dim());
      end
      n = $urandom_range(10, 80);
      repeat (n) push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
      sent += n;
    end
  endtask

  // Output side: random stall before each result unless dst_no_idle is set
  initial begin : result_sink
    int stall;
    forever begin
      stall = dst_no_idle ? 0 : $urandom_range(0, STALL_MAX);
      @(negedge clk);
      if (stall > 0) begin
        dst_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      dst_ready <= 1'b1;
      @(posedge clk);
      while (!dst_valid) @(posedge clk);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && dst_valid && dst_ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, dst_pixel);
      end else begin
        head_pixel = pending_pixels.pop_front();
        check_field("dest_x", head_pixel.dest_x, dst_pixel.dest_x);
        check_field("dest_y", head_pixel.dest_y, dst_pixel.dest_y);
        check_field("red", head_pixel.red, dst_pixel.red);
        check_field("green", head_pixel.green, dst_pixel.green);
        check_field("blue", head_pixel.blue, dst_pixel.blue);
        check_field("alpha", head_pixel.alpha, dst_pixel.alpha);
        check_field("frame_end", head_pixel.frame_end, dst_pixel.frame_end);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (dst_valid && dst_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_byte_formats();
    test_float_specials();
    test_half_specials();
    test_id_colours();
    test_reserved_codes();
    test_dimension_limits();
    test_counter_shrink();
    test_random_frames();
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: render_pixel_to_rgba8_core.f
+incdir+hw/rtl
hw/rtl/rpr8_pkg.sv
hw/rtl/rpr8_chan_conv.sv
hw/rtl/rpr8_pixel_conv.sv
hw/rtl/rpr8_raster_cnt.sv
hw/rtl/render_pixel_to_rgba8_core.sv
tb/sv/render_pixel_to_rgba8_core_tb.sv
